// File: hw/rtl/pdm_pkg.sv
package pdm_pkg;

  localparam int MAX_SAMPLES = 256;
  localparam int SAMPLE_W    = 32;
  localparam int SPREAD_W    = SAMPLE_W + 1;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int NP_W        = $clog2(MAX_SAMPLES * (MAX_SAMPLES - 1) / 2 + 1);
  localparam int GRD_W       = NP_W + 4;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic                last;
    logic [SAMPLE_W-1:0] sample;
  } pdm_item_t;

  typedef struct packed {
    logic      valid;
    pdm_item_t item;
  } pdm_head_t;

endpackage

// File: hw/rtl/pdm_ram.sv
module pdm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/pdm_front.sv
module pdm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [pdm_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                          last_sample_i,
  output pdm_pkg::pdm_head_t            head_o,
  input  logic                          pop_i
);

  pdm_pkg::pdm_item_t             fifo_q [pdm_pkg::FIFO_DEPTH];
  logic [pdm_pkg::FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [pdm_pkg::FIFO_AW:0]      fill_q;
  logic                           push, pop;

  assign busy_o = (fill_q == (pdm_pkg::FIFO_AW + 1)'(pdm_pkg::FIFO_DEPTH));
  assign push   = start_i & ~busy_o;
  assign pop    = pop_i & (fill_q != '0);

  assign head_o.valid = (fill_q != '0);
  assign head_o.item  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{last: last_sample_i, sample: sample_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// File: hw/rtl/pdm_back.sv
module pdm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pdm_pkg::pdm_head_t            head_i,
  output logic                          pop_o,
  output logic                          done_o,
  output logic [pdm_pkg::SPREAD_W-1:0]  spread_doubled_o,
  output logic                          overflow_o
);

  localparam int SW  = pdm_pkg::SAMPLE_W;
  localparam int CW  = pdm_pkg::CNT_W;
  localparam int IW  = pdm_pkg::IDX_W;
  localparam int NW  = pdm_pkg::NP_W;
  localparam int GW  = pdm_pkg::GRD_W;
  localparam int RW  = pdm_pkg::SPREAD_W;

  typedef enum logic [4:0] {
    S_IDLE, S_INS_CMP, S_START, S_PAIR, S_PIV0, S_INIT,
    S_CNT_ROW, S_CNT_WALK, S_CNT_END,
    S_MID_RD, S_MID_A, S_MID_B, S_MID_C, S_MID_END,
    S_SHR_RD, S_SHR_WR, S_SHR_END,
    S_SEL_RD, S_SEL_CHK, S_SEL_PIV
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   cnt_n_q, p_q, i_q, j_q, bnd_l_q, bnd_r_q;
  logic            dropped_q, last_q, even_q, prev_vld_q, mode_mid_q;
  logic            have_lo_q, have_hi_q, any_q;
  logic [SW-1:0]   v_q, xjm1_q, lo_q, hi_q, mn_q, mx_q, xl_q, xr_q;
  logic [NW-1:0]   np_q, klo_q, khi_q, tot_q, prev_q, act_q, half_q, acc_q;
  logic [GW-1:0]   guard_q, iter_q;
  logic [RW-1:0]   pivot_q, res_q;
  logic            done_q, ovf_q;

  // store ports
  logic            s_we;
  logic [IW-1:0]   s_waddr, sa_raddr, sb_raddr;
  logic [SW-1:0]   s_wdata, xa, xb;
  logic            row_we;
  logic [IW-1:0]   row_waddr, row_raddr;
  logic [2*CW-1:0] row_wdata, row_rdata;
  logic            c_we;
  logic [IW-1:0]   c_waddr, c_raddr;
  logic [CW-1:0]   c_wdata, c_rdata;

  // datapath
  logic [CW-1:0]   n, jn, c_row, row_l, row_h, lo2, hi2, col, sz, sz2, last_row;
  logic [SW:0]     gab_w, gba_w;
  logic [SW-1:0]   gab, gba, dlo, rmin, rmax;
  logic            adv, shift, last_i, exhaust;
  logic [2*CW-1:0] prod;
  logic [RW-1:0]   mid, two_mn, two_mx, piv_mid, settle_val, final_val;
  logic [NW+1:0]   dl, dh;
  logic            fin;
  logic [RW-1:0]   fin_val;

  function automatic logic [RW-1:0] settle_f(input logic even, input logic ge,
                                             input logic hl, input logic [SW-1:0] lo,
                                             input logic hh, input logic [SW-1:0] hi);
    logic [RW-1:0] r;
    if (even) begin
      if (hl && hh)   r = {1'b0, lo} + {1'b0, hi};
      else if (hl)    r = {lo, 1'b0};
      else if (hh)    r = {hi, 1'b0};
      else            r = '0;
    end else if (ge) begin
      r = hl ? {lo, 1'b0} : (hh ? {hi, 1'b0} : '0);
    end else begin
      r = hh ? {hi, 1'b0} : (hl ? {lo, 1'b0} : '0);
    end
    return r;
  endfunction

  pdm_ram #(.WIDTH(SW), .DEPTH(pdm_pkg::MAX_SAMPLES)) u_store_a (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(sa_raddr), .rdata_o(xa)
  );
  pdm_ram #(.WIDTH(SW), .DEPTH(pdm_pkg::MAX_SAMPLES)) u_store_b (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(sb_raddr), .rdata_o(xb)
  );
  pdm_ram #(.WIDTH(2*CW), .DEPTH(pdm_pkg::MAX_SAMPLES)) u_rows (
    .clk_i, .we_i(row_we), .waddr_i(row_waddr), .wdata_i(row_wdata),
    .raddr_i(row_raddr), .rdata_o(row_rdata)
  );
  pdm_ram #(.WIDTH(CW), .DEPTH(pdm_pkg::MAX_SAMPLES)) u_below (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  always_comb begin
    n        = cnt_n_q;
    last_row = n - CW'(2);
    last_i   = (i_q == last_row);
    gab_w    = {xb[SW-1], xb} - {xa[SW-1], xa};
    gba_w    = {xa[SW-1], xa} - {xb[SW-1], xb};
    gab      = gab_w[SW-1:0];
    gba      = gba_w[SW-1:0];
    jn       = (j_q < i_q + CW'(1)) ? i_q + CW'(1) : j_q;
    adv      = (j_q < n) && ({gab, 1'b0} < pivot_q);
    c_row    = j_q - (i_q + CW'(1));
    dlo      = xjm1_q - xa;
    shift    = $signed(xa) > $signed(v_q);
    prod     = {{CW{1'b0}}, n} * {{CW{1'b0}}, n - CW'(1)};
    row_l    = row_rdata[2*CW-1:CW];
    row_h    = row_rdata[CW-1:0];
    sz       = row_h - row_l + CW'(1);
    col      = CW'(({1'b0, row_l} + {1'b0, row_h}) >> 1);
    rmin     = xl_q - xa;
    rmax     = xr_q - xa;
    two_mn   = {mn_q, 1'b0};
    two_mx   = {mx_q, 1'b0};
    mid      = {1'b0, mn_q} + {1'b0, mx_q};
    piv_mid  = (mid > two_mn && mid <= two_mx) ? mid : two_mx;
    exhaust  = (iter_q + GW'(1) == guard_q);
    settle_val = settle_f(even_q, tot_q >= klo_q, have_lo_q, lo_q, have_hi_q, hi_q);
    dl = {2'b0, klo_q} - (NW + 2)'(1) - {2'b0, tot_q};
    if (dl[NW+1]) dl = -dl;
    dh = {2'b0, tot_q} - {2'b0, klo_q};
    if (dh[NW+1]) dh = -dh;
    final_val = even_q ? mid : ((dl <= dh) ? two_mn : two_mx);

    // window shrink, emptied rows marked as (1,0)
    lo2 = row_l;
    hi2 = row_h;
    if (tot_q < klo_q) begin
      if (i_q + CW'(1) + c_rdata > row_l) lo2 = i_q + CW'(1) + c_rdata;
      if (lo2 > hi2) begin
        lo2 = CW'(1);
        hi2 = '0;
      end
    end else begin
      if (i_q + c_rdata < row_h) hi2 = i_q + c_rdata;
      if (hi2 < i_q + CW'(1)) begin
        lo2 = CW'(1);
        hi2 = '0;
      end
    end
    sz2 = hi2 - lo2 + CW'(1);

    fin     = 1'b0;
    fin_val = '0;
    case (state_q)
      S_START:   fin = (n <= CW'(1));
      S_PAIR: begin
        fin     = 1'b1;
        fin_val = {gab, 1'b0};
      end
      S_CNT_END: begin
        fin     = (tot_q == klo_q) || (tot_q == khi_q - NW'(1));
        fin_val = settle_val;
      end
      S_MID_END: begin
        if (!mode_mid_q) begin
          fin     = 1'b1;
          fin_val = final_val;
        end else if (act_q == '0) begin
          fin     = 1'b1;
          fin_val = settle_val;
        end else if (mx_q <= mn_q) begin
          fin     = 1'b1;
          fin_val = two_mn;
        end else begin
          fin     = exhaust;
          fin_val = settle_val;
        end
      end
      S_SHR_END: begin
        fin     = (act_q == '0);
        fin_val = settle_val;
      end
      S_SEL_PIV: begin
        fin     = exhaust;
        fin_val = settle_val;
      end
      default: fin = 1'b0;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    s_we      = 1'b0;
    s_waddr   = '0;
    s_wdata   = v_q;
    sa_raddr  = i_q[IW-1:0];
    sb_raddr  = '0;
    row_we    = 1'b0;
    row_waddr = i_q[IW-1:0];
    row_wdata = {lo2, hi2};
    row_raddr = i_q[IW-1:0];
    c_we      = 1'b0;
    c_waddr   = i_q[IW-1:0];
    c_wdata   = c_row;
    c_raddr   = i_q[IW-1:0];
    case (state_q)
      S_IDLE: begin
        pop_o = head_i.valid;
        if (head_i.valid && cnt_n_q != CW'(pdm_pkg::MAX_SAMPLES)) begin
          if (cnt_n_q == '0) begin
            s_we    = 1'b1;
            s_wdata = head_i.item.sample;
          end else begin
            sa_raddr = IW'(cnt_n_q - CW'(1));
          end
        end
      end
      S_INS_CMP: begin
        s_we = 1'b1;
        if (p_q == '0) begin
          s_waddr = '0;
        end else if (shift) begin
          s_waddr  = p_q[IW-1:0];
          s_wdata  = xa;
          sa_raddr = IW'(p_q - CW'(2));
        end else begin
          s_waddr = p_q[IW-1:0];
        end
      end
      S_START: begin
        sa_raddr = IW'((n - CW'(1)) >> 1);
        sb_raddr = IW'(n >> 1);
      end
      S_INIT: begin
        row_we    = 1'b1;
        row_wdata = {i_q + CW'(1), n - CW'(1)};
      end
      S_CNT_ROW:  sb_raddr = jn[IW-1:0];
      S_CNT_WALK: begin
        sb_raddr = IW'(j_q + CW'(1));
        c_we     = !adv;
      end
      S_MID_A: begin
        sa_raddr = row_l[IW-1:0];
        sb_raddr = row_h[IW-1:0];
      end
      S_SHR_WR:  row_we = 1'b1;
      S_SEL_CHK: begin
        sa_raddr = col[IW-1:0];
        sb_raddr = i_q[IW-1:0];
      end
      default: pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_n_q    <= '0;
      dropped_q  <= 1'b0;
      prev_vld_q <= 1'b0;
      pivot_q    <= '0;
      done_q     <= 1'b0;
      res_q      <= '0;
      ovf_q      <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (head_i.valid) begin
            last_q <= head_i.item.last;
            v_q    <= head_i.item.sample;
            if (cnt_n_q == CW'(pdm_pkg::MAX_SAMPLES)) begin
              dropped_q <= 1'b1;
              if (head_i.item.last) state_q <= S_START;
            end else if (cnt_n_q == '0) begin
              cnt_n_q <= CW'(1);
              if (head_i.item.last) state_q <= S_START;
            end else begin
              p_q     <= cnt_n_q;
              state_q <= S_INS_CMP;
            end
          end
        end
        S_INS_CMP: begin
          if (p_q != '0 && shift) begin
            p_q <= p_q - CW'(1);
          end else begin
            cnt_n_q <= cnt_n_q + CW'(1);
            state_q <= last_q ? S_START : S_IDLE;
          end
        end
        S_START: begin
          np_q    <= prod[NW:1];
          state_q <= (n == CW'(2)) ? S_PAIR : S_PIV0;
        end
        S_PIV0: begin
          pivot_q    <= {gab, 1'b0};
          klo_q      <= NW'(({1'b0, np_q} + (NW + 1)'(1)) >> 1);
          khi_q      <= NW'(({1'b0, np_q} + (NW + 1)'(2)) >> 1);
          even_q     <= ~np_q[0];
          guard_q    <= GW'({np_q, 1'b0}) + GW'(8);
          iter_q     <= '0;
          prev_vld_q <= 1'b0;
          i_q        <= '0;
          state_q    <= S_INIT;
        end
        S_INIT: begin
          if (last_i) begin
            i_q       <= '0;
            j_q       <= CW'(1);
            tot_q     <= '0;
            have_lo_q <= 1'b0;
            have_hi_q <= 1'b0;
            state_q   <= S_CNT_ROW;
          end else begin
            i_q <= i_q + CW'(1);
          end
        end
        S_CNT_ROW: begin
          j_q     <= jn;
          state_q <= S_CNT_WALK;
        end
        S_CNT_WALK: begin
          if (adv) begin
            xjm1_q <= xb;
            j_q    <= j_q + CW'(1);
          end else begin
            tot_q <= tot_q + NW'(c_row);
            if (c_row != '0 && (!have_lo_q || dlo > lo_q)) begin
              lo_q      <= dlo;
              have_lo_q <= 1'b1;
            end
            if (j_q < n && (!have_hi_q || gab < hi_q)) begin
              hi_q      <= gab;
              have_hi_q <= 1'b1;
            end
            i_q     <= i_q + CW'(1);
            state_q <= last_i ? S_CNT_END : S_CNT_ROW;
          end
        end
        S_CNT_END: begin
          i_q   <= '0;
          act_q <= '0;
          any_q <= 1'b0;
          if (prev_vld_q && tot_q == prev_q) begin
            mode_mid_q <= 1'b1;
            state_q    <= S_MID_RD;
          end else begin
            state_q <= S_SHR_RD;
          end
        end
        S_MID_RD: state_q <= S_MID_A;
        S_MID_A: begin
          if (row_l > row_h) begin
            i_q     <= i_q + CW'(1);
            state_q <= last_i ? S_MID_END : S_MID_RD;
          end else begin
            bnd_l_q <= row_l;
            bnd_r_q <= row_h;
            state_q <= S_MID_B;
          end
        end
        S_MID_B: begin
          xl_q    <= xa;
          xr_q    <= xb;
          state_q <= S_MID_C;
        end
        S_MID_C: begin
          if (!any_q || rmin < mn_q) mn_q <= rmin;
          if (!any_q || rmax > mx_q) mx_q <= rmax;
          any_q <= 1'b1;
          if (mode_mid_q) act_q <= act_q + NW'(bnd_r_q - bnd_l_q + CW'(1));
          i_q     <= i_q + CW'(1);
          state_q <= last_i ? S_MID_END : S_MID_RD;
        end
        S_MID_END: begin
          pivot_q    <= piv_mid;
          prev_q     <= tot_q;
          prev_vld_q <= 1'b1;
          iter_q     <= iter_q + GW'(1);
          i_q        <= '0;
          j_q        <= CW'(1);
          tot_q      <= '0;
          have_lo_q  <= 1'b0;
          have_hi_q  <= 1'b0;
          state_q    <= S_CNT_ROW;
        end
        S_SHR_RD: state_q <= S_SHR_WR;
        S_SHR_WR: begin
          if (lo2 <= hi2) act_q <= act_q + NW'(sz2);
          i_q     <= i_q + CW'(1);
          state_q <= last_i ? S_SHR_END : S_SHR_RD;
        end
        S_SHR_END: begin
          prev_q     <= tot_q;
          prev_vld_q <= 1'b1;
          i_q        <= '0;
          if (act_q <= NW'(2)) begin
            mode_mid_q <= 1'b0;
            any_q      <= 1'b0;
            state_q    <= S_MID_RD;
          end else begin
            half_q  <= act_q >> 1;
            acc_q   <= '0;
            state_q <= S_SEL_RD;
          end
        end
        S_SEL_RD: state_q <= S_SEL_CHK;
        S_SEL_CHK: begin
          if (row_l <= row_h && half_q < acc_q + NW'(sz)) begin
            state_q <= S_SEL_PIV;
          end else begin
            if (row_l <= row_h) acc_q <= acc_q + NW'(sz);
            i_q     <= i_q + CW'(1);
            state_q <= S_SEL_RD;
          end
        end
        S_SEL_PIV: begin
          pivot_q   <= {gba, 1'b0};
          iter_q    <= iter_q + GW'(1);
          i_q       <= '0;
          j_q       <= CW'(1);
          tot_q     <= '0;
          have_lo_q <= 1'b0;
          have_hi_q <= 1'b0;
          state_q   <= S_CNT_ROW;
        end
        default: state_q <= S_IDLE;
      endcase
      if (fin) begin
        done_q    <= 1'b1;
        res_q     <= fin_val;
        ovf_q     <= dropped_q;
        dropped_q <= 1'b0;
        cnt_n_q   <= '0;
        state_q   <= S_IDLE;
      end
    end
  end

  assign done_o           = done_q;
  assign spread_doubled_o = res_q;
  assign overflow_o       = ovf_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe held longer than one cycle");

  a_done_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (cnt_n_q == '0 && !dropped_q && state_q == S_IDLE))
    else $error("store not emptied after result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_n_q <= CW'(pdm_pkg::MAX_SAMPLES)) else $error("sample count beyond store");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CNT_WALK |-> j_q > i_q) else $error("column pointer behind row");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == S_IDLE) else $error("queue popped while busy");

endmodule

// File: hw/rtl/pairwise_difference_median_core.sv
// Median pairwise absolute difference of a streamed data set. Drive start with
// one signed sample per transaction; a transaction is taken on a clock edge with
// start high and busy low. Mark the final sample of the set with last_sample_i.
// A four-deep queue takes samples at one per cycle while busy is low; the back end
// inserts each into an ascending store, shifting every stored entry larger than the
// new sample up by one, so busy rises when the queue fills.
// Up to 256 samples are kept; further ones are dropped and overflow_o is set
// with the result. After the marked sample the back end runs the selection:
// each pass sweeps the rows of the sorted store with a two-pointer walk, then a
// window update or pivot pass over the rows; the number of passes depends on the
// data. The result is spread_doubled_o (twice the median, one fraction bit) shown
// for exactly one cycle with done_o high; there is no way to hold it off, so
// capture it on that cycle. The store then empties and the next data set may
// begin.
module pairwise_difference_median_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [pdm_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                          last_sample_i,
  output logic                          done_o,
  output logic [pdm_pkg::SPREAD_W-1:0]  spread_doubled_o,
  output logic                          overflow_o
);

  pdm_pkg::pdm_head_t head;
  logic               pop;

  // front end: take and queue samples
  pdm_front u_front (
    .clk_i,
    .rst_ni,
    .start_i       (start),
    .busy_o        (busy),
    .sample_i,
    .last_sample_i,
    .head_o        (head),
    .pop_i         (pop)
  );

  // back end: sorted insert, then the selection sweeps
  pdm_back u_back (
    .clk_i,
    .rst_ni,
    .head_i           (head),
    .pop_o            (pop),
    .done_o,
    .spread_doubled_o,
    .overflow_o
  );

endmodule

// File: tb/pairwise_difference_median_core_tb.sv
module pairwise_difference_median_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation flags: ordinary sample, or the sample that closes a data set.
  localparam logic MID_SET = 1'b0;
  localparam logic END_SET = 1'b1;

  typedef struct {
    logic [pdm_pkg::SPREAD_W-1:0] spread;
    logic                         ovf;
  } spread_result_t;

  // One directed transaction; has_known marks a row whose answer is typed in.
  typedef struct {
    logic [pdm_pkg::SAMPLE_W-1:0] sample;
    logic                         last;
    bit                           has_known;
    logic [pdm_pkg::SPREAD_W-1:0] known_spread;
    logic                         known_ovf;
  } stim_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [pdm_pkg::SAMPLE_W-1:0] sample_i;
  logic                         last_sample_i;
  logic                         done_o;
  logic [pdm_pkg::SPREAD_W-1:0] spread_doubled_o;
  logic                         overflow_o;

  pairwise_difference_median_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .sample_i         (sample_i),
    .last_sample_i    (last_sample_i),
    .done_o           (done_o),
    .spread_doubled_o (spread_doubled_o),
    .overflow_o       (overflow_o)
  );

  // Predictor state: its own copy of the sorted store and selection windows.
  int             pred_store [pdm_pkg::MAX_SAMPLES];
  int             win_lo     [pdm_pkg::MAX_SAMPLES];
  int             win_hi     [pdm_pkg::MAX_SAMPLES];
  longint         row_below  [pdm_pkg::MAX_SAMPLES];
  int             pred_count;
  bit             pred_dropped;
  spread_result_t pending_spreads[$];
  int             mismatches;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("pairwise_difference_median_core_tb NOT OK");
    $finish;
  end

  function automatic longint pair_gap(int i, int j);
    return longint'(pred_store[j]) - longint'(pred_store[i]);
  endfunction

  // Final answer from the nearest differences below and at/above the pivot.
  function automatic longint settle_spread(bit even, longint cnt, longint klo,
                                           bit have_lo, longint lo,
                                           bit have_hi, longint hi);
    if (even) begin
      if (have_lo && have_hi) return lo + hi;
      if (have_lo) return 2 * lo;
      if (have_hi) return 2 * hi;
      return 0;
    end
    if (cnt >= klo) return have_lo ? 2 * lo : (have_hi ? 2 * hi : 0);
    return have_hi ? 2 * hi : (have_lo ? 2 * lo : 0);
  endfunction

  // Pivot search over the sorted store; the pivot and the result are held doubled.
  function automatic longint median_gap_doubled();
    int     n;
    int     i;
    int     j;
    int     row;
    int     col;
    longint np, klo, khi, guard, cnt, lo, hi, pivot, prev_cnt;
    longint active, mn, mx, c, d, mid, t, acc, sz, dl, dh;
    bit     even, have_lo, have_hi, any;
    n = pred_count;
    if (n <= 1) return 0;
    if (n == 2) return 2 * pair_gap(0, 1);
    np = (longint'(n) * longint'(n - 1)) / 2;
    klo = (np + 1) / 2;
    khi = (np + 2) / 2;
    even = klo < khi;
    cnt = 0; lo = 0; hi = 0; have_lo = 0; have_hi = 0;
    for (i = 0; i < n; i++) begin
      win_lo[i] = i + 1;
      win_hi[i] = n - 1;
      if (win_lo[i] > win_hi[i]) begin
        win_lo[i] = 1;
        win_hi[i] = 0;
      end
    end
    pivot = 2 * pair_gap((n - 1) / 2, n / 2);
    prev_cnt = -1;
    guard = 2 * np + 8;
    for (longint iter = 0; iter < guard; iter++) begin
      active = 0; mn = 0; mx = 0; any = 0;
      cnt = 0; have_lo = 0; have_hi = 0;
      j = 1;
      // Two-pointer sweep: count differences below the pivot per row.
      for (i = 0; i < n - 1; i++) begin
        if (j < i + 1) j = i + 1;
        while (j < n && 2 * pair_gap(i, j) < pivot) j++;
        c = j - (i + 1);
        row_below[i] = c;
        cnt += c;
        if (c > 0) begin
          d = pair_gap(i, j - 1);
          if (!have_lo || d > lo) begin lo = d; have_lo = 1; end
        end
        if (j < n) begin
          d = pair_gap(i, j);
          if (!have_hi || d < hi) begin hi = d; have_hi = 1; end
        end
      end
      if (cnt == klo || cnt == khi - 1)
        return settle_spread(even, cnt, klo, have_lo, lo, have_hi, hi);
      // Stalled count: retry with the midpoint of the remaining candidates.
      if (cnt == prev_cnt) begin
        for (i = 0; i < n - 1; i++) begin
          if (win_lo[i] > win_hi[i]) continue;
          if (!any || pair_gap(i, win_lo[i]) < mn) mn = pair_gap(i, win_lo[i]);
          if (!any || pair_gap(i, win_hi[i]) > mx) mx = pair_gap(i, win_hi[i]);
          any = 1;
          active += win_hi[i] - win_lo[i] + 1;
        end
        if (active <= 0)
          return settle_spread(even, cnt, klo, have_lo, lo, have_hi, hi);
        if (mx <= mn) return 2 * mn;
        mid = mn + mx;
        pivot = (mid > 2 * mn && mid <= 2 * mx) ? mid : 2 * mx;
        prev_cnt = cnt;
        continue;
      end
      // Shrink the row windows toward the middle rank.
      for (i = 0; i < n - 1; i++) begin
        if (cnt < klo) begin
          if (i + 1 + int'(row_below[i]) > win_lo[i])
            win_lo[i] = i + 1 + int'(row_below[i]);
          if (win_lo[i] > win_hi[i]) begin win_lo[i] = 1; win_hi[i] = 0; end
        end else begin
          if (i + int'(row_below[i]) < win_hi[i]) win_hi[i] = i + int'(row_below[i]);
          if (win_hi[i] < i + 1) begin win_lo[i] = 1; win_hi[i] = 0; end
        end
      end
      prev_cnt = cnt;
      for (i = 0; i < n - 1; i++)
        if (win_lo[i] <= win_hi[i]) active += win_hi[i] - win_lo[i] + 1;
      if (active <= 2) begin
        if (active <= 0)
          return settle_spread(even, cnt, klo, have_lo, lo, have_hi, hi);
        for (i = 0; i < n - 1; i++) begin
          if (win_lo[i] > win_hi[i]) continue;
          if (!any || pair_gap(i, win_lo[i]) < mn) mn = pair_gap(i, win_lo[i]);
          if (!any || pair_gap(i, win_hi[i]) > mx) mx = pair_gap(i, win_hi[i]);
          any = 1;
        end
        if (even) return mn + mx;
        dl = (klo - 1) - cnt;
        if (dl < 0) dl = -dl;
        dh = cnt - klo;
        if (dh < 0) dh = -dh;
        return 2 * ((dl <= dh) ? mn : mx);
      end
      // Next pivot: middle column of the row holding the middle candidate.
      t = active / 2; acc = 0; row = 0;
      for (i = 0; i < n - 1; i++) begin
        if (win_lo[i] > win_hi[i]) continue;
        sz = win_hi[i] - win_lo[i] + 1;
        if (t < acc + sz) begin row = i; break; end
        acc += sz;
      end
      col = (win_lo[row] + win_hi[row]) / 2;
      pivot = 2 * pair_gap(row, col);
    end
    return settle_spread(even, cnt, klo, have_lo, lo, have_hi, hi);
  endfunction

  // Insert one accepted sample; on the closing sample return its spread.
  function automatic bit absorb_sample(logic [pdm_pkg::SAMPLE_W-1:0] s, logic last,
                                       output spread_result_t res);
    int v;
    int p;
    v = signed'(s);
    if (pred_count < pdm_pkg::MAX_SAMPLES) begin
      p = pred_count;
      while (p > 0 && pred_store[p - 1] > v) begin
        pred_store[p] = pred_store[p - 1];
        p--;
      end
      pred_store[p] = v;
      pred_count++;
    end else begin
      pred_dropped = 1;
    end
    if (last != END_SET) return 0;
    res.spread = pdm_pkg::SPREAD_W'(median_gap_doubled());
    res.ovf = pred_dropped;
    pred_count = 0;
    pred_dropped = 0;
    return 1;
  endfunction

  // Hold start until the transaction is taken, then drop it while the gap runs.
  task automatic send_sample(logic [pdm_pkg::SAMPLE_W-1:0] s, logic last, int gap,
                             bit has_known, spread_result_t known);
    spread_result_t res;
    start <= 1'b1;
    sample_i <= s;
    last_sample_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (absorb_sample(s, last, res))
      pending_spreads.push_back(has_known ? known : res);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [pdm_pkg::SAMPLE_W-1:0] pick_sample(int style);
    case (style)
      0: return $urandom;
      1: return pdm_pkg::SAMPLE_W'($signed($urandom_range(0, 20)) - 10);
      2: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
      default: return pdm_pkg::SAMPLE_W'($urandom_range(0, 1000));
    endcase
  endfunction

  // Compare each done strobe against the oldest pending spread.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_spreads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result spread=%0d ovf=%0b", spread_doubled_o, overflow_o);
      end else begin
        if (spread_doubled_o !== pending_spreads[0].spread ||
            overflow_o !== pending_spreads[0].ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected spread=%0d ovf=%0b, got spread=%0d ovf=%0b",
                     pending_spreads[0].spread, pending_spreads[0].ovf,
                     spread_doubled_o, overflow_o);
        end
        void'(pending_spreads.pop_front());
      end
    end
  end

  stim_row_t directed[] = '{
    // single sample: spread is zero
    '{32'h7FFF_FFFF, END_SET, 1, 33'd0, 1'b0},
    // two extremes: twice the full range
    '{32'h8000_0000, MID_SET, 0, 33'd0, 1'b0},
    '{32'h7FFF_FFFF, END_SET, 1, 33'h1_FFFF_FFFE, 1'b0},
    // two equal samples
    '{32'h0000_0005, MID_SET, 0, 33'd0, 1'b0},
    '{32'h0000_0005, END_SET, 1, 33'd0, 1'b0},
    // three samples, extremes and zero
    '{32'h8000_0000, MID_SET, 0, 33'd0, 1'b0},
    '{32'h0000_0000, MID_SET, 0, 33'd0, 1'b0},
    '{32'h7FFF_FFFF, END_SET, 0, 33'd0, 1'b0},
    // all duplicates
    '{32'hFFFF_FFFF, MID_SET, 0, 33'd0, 1'b0},
    '{32'hFFFF_FFFF, MID_SET, 0, 33'd0, 1'b0},
    '{32'hFFFF_FFFF, MID_SET, 0, 33'd0, 1'b0},
    '{32'hFFFF_FFFF, END_SET, 1, 33'd0, 1'b0},
    // descending entry, even pair count (six pairs)
    '{32'h0000_0009, MID_SET, 0, 33'd0, 1'b0},
    '{32'h0000_0004, MID_SET, 0, 33'd0, 1'b0},
    '{32'hFFFF_FFFE, MID_SET, 0, 33'd0, 1'b0},
    '{32'hFFFF_FFF0, END_SET, 0, 33'd0, 1'b0},
    // five samples with mixed gaps
    '{32'h0000_0001, MID_SET, 0, 33'd0, 1'b0},
    '{32'h0000_0002, MID_SET, 0, 33'd0, 1'b0},
    '{32'h0000_0064, MID_SET, 0, 33'd0, 1'b0},
    '{32'h8000_0001, MID_SET, 0, 33'd0, 1'b0},
    '{32'h0000_0003, END_SET, 0, 33'd0, 1'b0}
  };

  initial begin
    spread_result_t known;
    int set_len;
    int style;
    int sent;
    int n_sets;
    pred_count = 0;
    pred_dropped = 0;
    mismatches = 0;
    start = 1'b0;
    sample_i = '0;
    last_sample_i = 1'b0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) begin
      known.spread = directed[k].known_spread;
      known.ovf = directed[k].known_ovf;
      send_sample(directed[k].sample, directed[k].last, pick_gap(),
                  directed[k].has_known, known);
    end

    // Random data sets; mostly short, a couple over capacity to force overflow.
    sent = 0;
    n_sets = 0;
    while (sent < 1700) begin
      if (n_sets == 20 || n_sets == 60)
        set_len = $urandom_range(pdm_pkg::MAX_SAMPLES + 1, pdm_pkg::MAX_SAMPLES + 12);
      else if ($urandom_range(0, 9) < 8)
        set_len = $urandom_range(1, 12);
      else
        set_len = $urandom_range(13, 40);
      style = $urandom_range(0, 3);
      for (int k = 0; k < set_len; k++)
        send_sample(pick_sample(style), (k == set_len - 1) ? END_SET : MID_SET,
                    (n_sets % 7 == 3) ? 0 : pick_gap(), 0, known);
      sent += set_len;
      n_sets++;
      // Hold off the sender until every pending spread has come back.
      if (n_sets % 25 == 0) begin
        start <= 1'b0;
        while (pending_spreads.size() != 0) @(posedge clk_i);
      end
    end

    start <= 1'b0;
    while (pending_spreads.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0)
      $display("pairwise_difference_median_core_tb OK");
    else
      $display("pairwise_difference_median_core_tb NOT OK");
    $finish;
  end

endmodule
